// ----- design/height_grid_slope_core_defines.svh -----
// assertion macros for the height grid slope core
`ifndef HEIGHT_GRID_SLOPE_CORE_DEFINES_SVH
`define HEIGHT_GRID_SLOPE_CORE_DEFINES_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define HGS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("height_grid_slope_core assertion failed");

// condition must never be seen outside reset
`define HGS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("height_grid_slope_core forbidden condition");

`else

`define HGS_ASSERT(lbl, clk, rst_n, prop)
`define HGS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- design/hgs_pkg.sv -----
`timescale 1ns / 1ps

package hgs_pkg;

    localparam int DEF_MAX_WIDTH   = 128;
    localparam int DEF_MAX_HEIGHT  = 128;
    localparam int DEF_HEIGHT_BITS = 16;

    localparam int COORD_BITS = 7;
    localparam int DIM_BITS   = 8;
    localparam int INV_BITS   = 16;
    localparam int SLOPE_BITS = 25;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [DIM_BITS-1:0] GRID_WIDTH_RST    = 8'd128;
    localparam logic [DIM_BITS-1:0] GRID_HEIGHT_RST   = 8'd128;
    localparam logic [INV_BITS-1:0] INV_CELL_SIZE_RST = 16'd256;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH    = 2'd0,
        CFG_GRID_HEIGHT   = 2'd1,
        CFG_INV_CELL_SIZE = 2'd2
    } cfg_index_t;

endpackage

// ----- design/hgs_item_if.sv -----
`timescale 1ns / 1ps

interface hgs_item_if
    import hgs_pkg::*;
#(
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [COORD_BITS-1:0]         cell_x;
    logic [COORD_BITS-1:0]         cell_y;
    logic signed [HEIGHT_BITS-1:0] height;

    modport source (output valid, action, cell_x, cell_y, height, input ready);
    modport sink (input valid, action, cell_x, cell_y, height, output ready);
endinterface

// ----- design/hgs_result_if.sv -----
`timescale 1ns / 1ps

interface hgs_result_if
    import hgs_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [SLOPE_BITS-1:0] slope_x;
    logic signed [SLOPE_BITS-1:0] slope_y;
    logic                         in_range;

    modport source (output valid, slope_x, slope_y, in_range, input ready);
    modport sink (input valid, slope_x, slope_y, in_range, output ready);
endinterface

// ----- design/hgs_cfg_if.sv -----
`timescale 1ns / 1ps

interface hgs_cfg_if
    import hgs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/height_grid_slope_core.sv -----
`timescale 1ns / 1ps
`include "height_grid_slope_core_defines.svh"
// height grid slope core
// item channel: action selects a cell write or a slope query at (cell_x, cell_y).
// a write gives no result and keeps the item channel ready; a query gives one result
// transaction on the result channel with slope_x, slope_y and in_range.
// cfg channel: always ready, writes grid_width, grid_height or inv_cell_size by index;
// write it only while no query is in flight.
// a query inside the grid reads five cells through the single port of the height
// memory, one read per cycle, then uses the shared multiplier for the x axis and
// then the y axis; the next item is taken only once the result is in the output register.
// a query outside the grid skips the reads and gives a zero result with in_range low.
// the result sits in an output register, so items keep coming while it waits;
// a query finishing while the receiver stalls holds until the register frees up.
// after reset the memory is swept to the invalid code, one cell per cycle, over all
// MAX_WIDTH * MAX_HEIGHT cells (16384 by default), with the item channel not ready.
// cfg writes are taken during that sweep.
module height_grid_slope_core
    import hgs_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    hgs_item_if.sink     item,
    hgs_result_if.source result,
    hgs_cfg_if.sink      cfg
);

    localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int DIFF_BITS = HEIGHT_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + INV_BITS + 1;

    localparam logic [HEIGHT_BITS-1:0] INVALID_CODE = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
    localparam logic [DIM_BITS-1:0] W_CAP = (MAX_WIDTH < 256) ? DIM_BITS'(MAX_WIDTH) : 8'hFF;
    localparam logic [DIM_BITS-1:0] H_CAP = (MAX_HEIGHT < 256) ? DIM_BITS'(MAX_HEIGHT) : 8'hFF;
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(CELLS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_MULX  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [2:0]           step_reg, step_next;

    logic [DIM_BITS-1:0] gw_reg;
    logic [DIM_BITS-1:0] gh_reg;
    logic [INV_BITS-1:0] inv_reg;

    logic [COORD_BITS-1:0] qx_reg, qy_reg;
    logic xp_ok_reg, xn_ok_reg, yp_ok_reg, yn_ok_reg, inr_reg;
    logic signed [HEIGHT_BITS-1:0] cell_reg [4];
    logic signed [SLOPE_BITS-1:0] slope_x_reg;

    logic [HEIGHT_BITS-1:0] mem [CELLS];
    logic [HEIGHT_BITS-1:0] rd_data_reg;
    logic                   mem_we, mem_re;
    logic [ADDR_BITS-1:0]   mem_addr;
    logic [HEIGHT_BITS-1:0] mem_wdata;

    logic                         out_valid_reg;
    logic signed [SLOPE_BITS-1:0] out_sx_reg, out_sy_reg;
    logic                         out_inr_reg;
    logic                         out_free, out_load;

    logic [DIM_BITS-1:0] gw_eff, gh_eff;
    logic item_acc, acc_write, acc_query, q_in_range;
    logic wr_inside;

    logic signed [HEIGHT_BITS-1:0] a_prev, a_mid, a_next;
    logic a_pok, a_nok, pv, mv, nv, central;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] prod, shifted;
    logic signed [SLOPE_BITS-1:0] slope;

    function automatic logic [ADDR_BITS-1:0] cell_addr(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y
    );
        logic [31:0] lin;
        lin = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
        return lin[ADDR_BITS-1:0];
    endfunction

    // grid size saturates to the store size
    assign gw_eff = (gw_reg > W_CAP) ? W_CAP : gw_reg;
    assign gh_eff = (gh_reg > H_CAP) ? H_CAP : gh_reg;

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign acc_write  = item_acc && (item.action == ACT_WRITE);
    assign acc_query  = item_acc && (item.action == ACT_QUERY);
    assign q_in_range = (DIM_BITS'(item.cell_x) < gw_eff) && (DIM_BITS'(item.cell_y) < gh_eff);
    assign wr_inside  = (int'(item.cell_x) < MAX_WIDTH) && (int'(item.cell_y) < MAX_HEIGHT);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= GRID_WIDTH_RST;
            gh_reg  <= GRID_HEIGHT_RST;
            inv_reg <= INV_CELL_SIZE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_GRID_WIDTH:    gw_reg  <= cfg.data[DIM_BITS-1:0];
                CFG_GRID_HEIGHT:   gh_reg  <= cfg.data[DIM_BITS-1:0];
                CFG_INV_CELL_SIZE: inv_reg <= cfg.data[INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // single-port memory access: sweep, cell write, or one query read
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = cell_addr(item.cell_x, item.cell_y);
        mem_wdata = item.height;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = INVALID_CODE;
        end
        else if (acc_write)
        begin
            mem_we = wr_inside;
        end
        else if (acc_query)
        begin
            mem_re = q_in_range;
        end
        else if (state_reg == S_READ)
        begin
            mem_re = 1'b1;
            unique case (step_reg)
                3'd1:    mem_addr = cell_addr(xp_ok_reg ? qx_reg - 7'd1 : qx_reg, qy_reg);
                3'd2:    mem_addr = cell_addr(xn_ok_reg ? qx_reg + 7'd1 : qx_reg, qy_reg);
                3'd3:    mem_addr = cell_addr(qx_reg, yp_ok_reg ? qy_reg - 7'd1 : qy_reg);
                3'd4:    mem_addr = cell_addr(qx_reg, yn_ok_reg ? qy_reg + 7'd1 : qy_reg);
                default: mem_addr = cell_addr(qx_reg, qy_reg);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // axis operands: x axis in S_MULX, y axis in S_EMIT (next row still in read data)
    always_comb
    begin
        a_mid = cell_reg[0];
        if (state_reg == S_MULX)
        begin
            a_prev = cell_reg[1];
            a_next = cell_reg[2];
            a_pok  = xp_ok_reg;
            a_nok  = xn_ok_reg;
        end
        else
        begin
            a_prev = cell_reg[3];
            a_next = $signed(rd_data_reg);
            a_pok  = yp_ok_reg;
            a_nok  = yn_ok_reg;
        end
        pv = a_pok && (a_prev != $signed(INVALID_CODE));
        mv = (a_mid != $signed(INVALID_CODE));
        nv = a_nok && (a_next != $signed(INVALID_CODE));
        central = 1'b0;
        if (nv && pv)
        begin
            diff    = DIFF_BITS'(a_next) - DIFF_BITS'(a_prev);
            central = 1'b1;
        end
        else if (nv && mv)
        begin
            diff = DIFF_BITS'(a_next) - DIFF_BITS'(a_mid);
        end
        else if (pv && mv)
        begin
            diff = DIFF_BITS'(a_mid) - DIFF_BITS'(a_prev);
        end
        else
        begin
            diff = '0;
        end
        prod    = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, inv_reg}));
        // central difference halves the step, so one more bit of shift
        shifted = central ? (prod >>> 9) : (prod >>> 8);
        slope   = SLOPE_BITS'(shifted);
    end

    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc_query)
                begin
                    state_next = q_in_range ? S_READ : S_EMIT;
                    step_next  = 3'd1;
                end
            end
            S_READ:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            step_reg    <= 3'd0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
        end
    end

    // query context and gathered cells
    always_ff @(posedge clk)
    begin
        if (acc_query)
        begin
            qx_reg    <= item.cell_x;
            qy_reg    <= item.cell_y;
            inr_reg   <= q_in_range;
            xp_ok_reg <= (item.cell_x != '0);
            xn_ok_reg <= (DIM_BITS'(item.cell_x) + 8'd1 < gw_eff);
            yp_ok_reg <= (item.cell_y != '0);
            yn_ok_reg <= (DIM_BITS'(item.cell_y) + 8'd1 < gh_eff);
        end
        if (state_reg == S_READ)
        begin
            cell_reg[2'(step_reg - 3'd1)] <= $signed(rd_data_reg);
        end
        if (state_reg == S_MULX)
        begin
            slope_x_reg <= slope;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sx_reg  <= inr_reg ? slope_x_reg : '0;
            out_sy_reg  <= inr_reg ? slope : '0;
            out_inr_reg <= inr_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.slope_x  = out_sx_reg;
    assign result.slope_y  = out_sy_reg;
    assign result.in_range = out_inr_reg;

    `HGS_ASSERT(a_clear_ends_idle, clk, rst_n, (state_reg == S_CLEAR && clr_cnt_reg == LAST_ADDR) |=> (state_reg == S_IDLE))
    `HGS_ASSERT_NEVER(a_write_in_query, clk, rst_n, mem_we && (state_reg == S_READ || state_reg == S_MULX || state_reg == S_EMIT))
    `HGS_ASSERT_NEVER(a_out_overwrite, clk, rst_n, out_load && out_valid_reg && !result.ready)
    `HGS_ASSERT(a_oor_zero, clk, rst_n, (result.valid && !result.in_range) |-> (result.slope_x == '0 && result.slope_y == '0))
    `HGS_ASSERT(a_read_to_mul, clk, rst_n, (state_reg == S_READ && step_reg == 3'd4) |=> (state_reg == S_MULX))

endmodule

// ----- verif/hgs_slope_checker.sv -----
`timescale 1ns / 1ps

module hgs_slope_checker
    import hgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hgs_item_if         item,
    hgs_result_if       result,
    hgs_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam logic signed [DEF_HEIGHT_BITS-1:0] NO_HEIGHT = 16'sh8000;

    typedef struct packed {
        logic signed [SLOPE_BITS-1:0] slope_x;
        logic signed [SLOPE_BITS-1:0] slope_y;
        logic                         in_range;
    } slope_result_t;

    logic signed [DEF_HEIGHT_BITS-1:0] heights [0:CELLS-1];
    logic [DIM_BITS-1:0] grid_w;
    logic [DIM_BITS-1:0] grid_h;
    logic [INV_BITS-1:0] inv_cell;
    slope_result_t       slope_q [$];
    int unsigned         fails;

    function automatic logic signed [SLOPE_BITS-1:0] axis_slope(
        logic signed [DEF_HEIGHT_BITS-1:0] prev,
        logic signed [DEF_HEIGHT_BITS-1:0] mid,
        logic signed [DEF_HEIGHT_BITS-1:0] nxt
    );
        longint prod;
        bit     pv;
        bit     mv;
        bit     nv;
        pv = (prev != NO_HEIGHT);
        mv = (mid != NO_HEIGHT);
        nv = (nxt != NO_HEIGHT);
        prod = 0;
        // central difference halves through the extra shift bit
        if (nv && pv)
            prod = ((longint'(nxt) - longint'(prev)) * longint'(inv_cell)) >>> 9;
        else if (nv && mv)
            prod = ((longint'(nxt) - longint'(mid)) * longint'(inv_cell)) >>> 8;
        else if (pv && mv)
            prod = ((longint'(mid) - longint'(prev)) * longint'(inv_cell)) >>> 8;
        return prod[SLOPE_BITS-1:0];
    endfunction

    function automatic slope_result_t predict_slope(
        logic [COORD_BITS-1:0] x,
        logic [COORD_BITS-1:0] y
    );
        slope_result_t r;
        int w;
        int h;
        logic signed [DEF_HEIGHT_BITS-1:0] c;
        logic signed [DEF_HEIGHT_BITS-1:0] xp;
        logic signed [DEF_HEIGHT_BITS-1:0] xn;
        logic signed [DEF_HEIGHT_BITS-1:0] yp;
        logic signed [DEF_HEIGHT_BITS-1:0] yn;
        // oversized grid saturates to the store size
        w = (grid_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(grid_w);
        h = (grid_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(grid_h);
        r = '0;
        if (int'(x) >= w || int'(y) >= h)
            return r;
        c  = heights[{y, x}];
        xp = (x > 0) ? heights[{y, x - 7'd1}] : NO_HEIGHT;
        xn = (int'(x) + 1 < w) ? heights[{y, x + 7'd1}] : NO_HEIGHT;
        yp = (y > 0) ? heights[{y - 7'd1, x}] : NO_HEIGHT;
        yn = (int'(y) + 1 < h) ? heights[{y + 7'd1, x}] : NO_HEIGHT;
        r.slope_x  = axis_slope(xp, c, xn);
        r.slope_y  = axis_slope(yp, c, yn);
        r.in_range = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slope_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                heights[i] = NO_HEIGHT;
            grid_w   = GRID_WIDTH_RST;
            grid_h   = GRID_HEIGHT_RST;
            inv_cell = INV_CELL_SIZE_RST;
            slope_q.delete();
            fails = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (slope_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with nothing pending: sx=%0d sy=%0d in_range=%0b",
                                 $realtime, result.slope_x, result.slope_y, result.in_range);
                end
                else
                begin
                    want = slope_q.pop_front();
                    if (result.slope_x !== want.slope_x || result.slope_y !== want.slope_y
                        || result.in_range !== want.in_range)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: slope mismatch: exp sx=%0d sy=%0d in_range=%0b,",
                                     $realtime, want.slope_x, want.slope_y, want.in_range,
                                     " got sx=%0d sy=%0d in_range=%0b",
                                     result.slope_x, result.slope_y, result.in_range);
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_GRID_WIDTH:    grid_w   = cfg.data[DIM_BITS-1:0];
                    CFG_GRID_HEIGHT:   grid_h   = cfg.data[DIM_BITS-1:0];
                    CFG_INV_CELL_SIZE: inv_cell = cfg.data[INV_BITS-1:0];
                    default: ;
                endcase
            end

            if (item.valid && item.ready)
            begin
                if (item.action == ACT_WRITE)
                    heights[{item.cell_y, item.cell_x}] = item.height;
                else
                    slope_q = {slope_q, predict_slope(item.cell_x, item.cell_y)};
            end

            outstanding <= slope_q.size();
            mismatches  <= fails;
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import hgs_pkg::*;

    logic        clk;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned outstanding;
    int          dim_x;
    int          dim_y;
    int          burst_left;

    hgs_item_if   item_ch ();
    hgs_result_if res_ch ();
    hgs_cfg_if    cfg_ch ();

    height_grid_slope_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    hgs_slope_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (res_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // result side: randomly chosen stall modes, plus one long hold after twelve results
    initial
    begin
        int mode;
        int left;
        int seen;
        bit held;
        mode = 0;
        left = 0;
        seen = 0;
        held = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                seen++;
            if (!held && seen >= 12)
            begin
                held = 1;
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(2, 0);
                    left = $urandom_range(200, 20);
                end
                left--;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(3, 0) != 0);
                    default: res_ch.ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    task automatic idle(input int n);
        item_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(input logic act, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y, input logic [15:0] h);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
                idle(gap);
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.cell_x <= x;
        item_ch.cell_y <= y;
        item_ch.height <= h;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // stop sending and wait for every pending slope, then let a trailing write settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic program_grid(input logic [15:0] w_data, input logic [15:0] h_data,
                                input logic [15:0] inv_data);
        logic [15:0] vals [3];
        cfg_index_t  regs [3];
        int          i;
        vals = '{w_data, h_data, inv_data};
        regs = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_INV_CELL_SIZE};
        for (i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        dim_x = (w_data[7:0] > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w_data[7:0]);
        dim_y = (h_data[7:0] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(h_data[7:0]);
    endtask

    // coordinates clustered near the low or high grid edge so neighbours get written
    function automatic logic [COORD_BITS-1:0] pick_coord(input int dim, input bit high_side);
        int lo;
        int hi;
        if (high_side)
        begin
            hi = (dim > 127) ? 127 : dim;
            lo = (hi > 4) ? hi - 4 : 0;
        end
        else
        begin
            lo = 0;
            hi = 4;
        end
        return COORD_BITS'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] pick_height();
        int sel;
        sel = $urandom_range(9, 0);
        case (sel)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h8001;
            3, 4:    return 16'($urandom_range(64, 0) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(input int n);
        int i;
        int region;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        for (i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain();
            region = $urandom_range(19, 0);
            if (region < 3)
            begin
                x = COORD_BITS'($urandom);
                y = COORD_BITS'($urandom);
            end
            else
            begin
                x = pick_coord(dim_x, region[0]);
                y = pick_coord(dim_y, region[1]);
            end
            send_item(logic'($urandom_range(1, 0)), x, y, pick_height());
        end
    endtask

    initial
    begin
        int phase;
        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.action <= ACT_WRITE;
        item_ch.cell_x <= '0;
        item_ch.cell_y <= '0;
        item_ch.height <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_GRID_WIDTH;
        cfg_ch.data    <= '0;
        burst_left = 0;
        dim_x = DEF_MAX_WIDTH;
        dim_y = DEF_MAX_HEIGHT;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: program_grid(16'd128, 16'd128, 16'd256);
                1: program_grid(16'hFFFF, 16'h3A80, 16'hFFFF);
                2: program_grid(16'd1, 16'd1, 16'd0);
                3: program_grid(16'd0, 16'd6, 16'd384);
                4: program_grid(16'd3, 16'd255, 16'd1);
                5: program_grid(16'($urandom_range(24, 2)), 16'($urandom_range(24, 2)),
                                16'($urandom));
                default: program_grid(16'd128, 16'($urandom_range(127, 100)),
                                      16'($urandom));
            endcase

            if (phase == 0)
            begin
                // empty grid, then one-sided steps at both corners
                send_item(ACT_QUERY, 7'd0, 7'd0, 16'h8000);
                send_item(ACT_WRITE, 7'd0, 7'd0, 16'h7FFF);
                send_item(ACT_WRITE, 7'd1, 7'd0, 16'h8001);
                send_item(ACT_QUERY, 7'd0, 7'd0, 16'h7FFF);
                send_item(ACT_WRITE, 7'd127, 7'd127, 16'h8001);
                send_item(ACT_WRITE, 7'd126, 7'd127, 16'h7FFF);
                send_item(ACT_QUERY, 7'd127, 7'd127, 16'h0000);
                // central differences around an invalid center
                send_item(ACT_WRITE, 7'd5, 7'd4, 16'd100);
                send_item(ACT_WRITE, 7'd5, 7'd6, 16'hFFF9);
                send_item(ACT_WRITE, 7'd4, 7'd5, 16'h8000);
                send_item(ACT_QUERY, 7'd5, 7'd5, 16'hFFFF);
                send_item(ACT_WRITE, 7'd6, 7'd5, 16'h7FFF);
                send_item(ACT_WRITE, 7'd4, 7'd5, 16'h8001);
                send_item(ACT_QUERY, 7'd5, 7'd5, 16'h5555);
                // neighbour valid but center invalid, then forward and backward
                send_item(ACT_WRITE, 7'd21, 7'd20, 16'd5);
                send_item(ACT_QUERY, 7'd20, 7'd20, 16'hAAAA);
                send_item(ACT_WRITE, 7'd20, 7'd20, 16'd0);
                send_item(ACT_WRITE, 7'd20, 7'd19, 16'hFFFD);
                send_item(ACT_QUERY, 7'd20, 7'd20, 16'h8000);
            end
            else if (phase == 1)
            begin
                // largest reciprocal on the extreme differences
                send_item(ACT_QUERY, 7'd5, 7'd5, 16'h0000);
                send_item(ACT_QUERY, 7'd127, 7'd127, 16'hFFFF);
                send_item(ACT_QUERY, 7'd0, 7'd0, 16'h7FFF);
            end

            random_items(128);
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
